### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; SYNTH turns every check into an empty statement
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

### hdl/asll_pkg.sv
// types, constants and codes of the address symbol/line lookup
// no dependencies
`default_nettype none
package asll_pkg;
	localparam int SYMBOL_DEPTH_DEF = 4096;
	localparam int LINE_DEPTH_DEF   = 4096;
	localparam int COUNT_W          = 13;
	localparam logic [15:0] LINE_SAT  = 16'hFFFF;
	localparam logic [31:0] LAST_SPAN = 32'd65536;

	localparam logic CFG_SYMBOL_COUNT = 1'b0;
	localparam logic CFG_LINE_COUNT   = 1'b1;

	localparam logic [1:0] MODE_WSYM  = 2'd0;
	localparam logic [1:0] MODE_WLINE = 2'd1;
	localparam logic [1:0] MODE_LOOK  = 2'd2;

	typedef enum logic [1:0] {
		OP_WSYM  = 2'd0,
		OP_WLINE = 2'd1,
		OP_LOOK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] entry_index;
		logic [31:0] address;
		logic [31:0] entry_size;
		logic [31:0] entry_name_offset;
		logic [31:0] line_value;
		logic [15:0] entry_file_index;
	} cmd_t;

	typedef struct packed {
		logic        found_symbol;
		logic [31:0] symbol_name_ofs;
		logic        found_line;
		logic [15:0] hit_line_number;
		logic [15:0] hit_file_index;
		logic        hit;
	} result_t;

	// queued, already decoded transaction
	typedef struct packed {
		op_t         op;
		logic [11:0] slot;
		logic [31:0] address;
		logic [31:0] size;
		logic [31:0] name;
		logic [31:0] info;
	} entry_t;
endpackage
`default_nettype wire

### hdl/address_symbol_line_lookup.sv
// lookup: each probe of the wider binary search (both tables probed together)
//   passes ST_PROBE then ST_CHECK; done is registered when no search is left active
// table writes, unused commands: done registered at pop, one per cycle unless a search runs
// a two-entry command queue takes new commands while a search runs; busy when full
// done is a one-cycle strobe, the receiver cannot stall; reset clears counts and queue,
//   table contents stay undefined until written
// top level; depends on asll_pkg, asll_front, asll_back, asll_ram, assert_macros.svh
`include "assert_macros.svh"
`default_nettype none
module address_symbol_line_lookup import asll_pkg::*; #(
	parameter int SYMBOL_DEPTH = SYMBOL_DEPTH_DEF,
	parameter int LINE_DEPTH   = LINE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire cmd_t               cmd,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [COUNT_W-1:0] cfg_data,
	output logic                    done,
	output result_t                 result
);
	// configuration registers: entries searched per table
	logic [COUNT_W-1:0] symbol_count_q;
	logic [COUNT_W-1:0] line_count_q;

	// front to back queue handshake
	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= '0;
			line_count_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYMBOL_COUNT: symbol_count_q <= cfg_data;
				CFG_LINE_COUNT:   line_count_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// front: accept each transaction while not busy, decode mode, saturate line number, queue it
	asll_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	// back: table writes and the two searches over the memories
	asll_back #(
		.SYMBOL_DEPTH (SYMBOL_DEPTH),
		.LINE_DEPTH   (LINE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.symbol_count (symbol_count_q),
		.line_count   (line_count_q),
		.done         (done),
		.result       (result)
	);

	// a result without a symbol match carries no name offset
	`ASSERT_CLK(a_no_sym_name, clk, arst_n, done && !result.found_symbol |-> result.symbol_name_ofs == 32'd0)
	// a result without a line match carries no line info
	`ASSERT_CLK(a_no_line_info, clk, arst_n, done && !result.found_line |-> result.hit_line_number == 16'd0 && result.hit_file_index == 16'd0)
	// any match raises hit
	`ASSERT_NEVER(a_match_hit, clk, arst_n, done && (result.found_symbol || result.found_line) && !result.hit)
	// the back end only pops when the queue holds something
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, q_pop && !q_valid)
endmodule
`default_nettype wire

### hdl/asll_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module asll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hdl/asll_front.sv
// front end: accepts commands, decodes them and holds a two-entry queue
// depends on asll_pkg
`default_nettype none
module asll_front import asll_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire cmd_t   cmd,
	output logic        q_valid,
	output entry_t      q_entry,
	input  wire logic   q_pop
);
	entry_t     q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	entry_t     dec;

	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_entry = q_mem_q[rd_ptr_q];

	always_comb begin
		dec.slot    = cmd.entry_index;
		dec.address = cmd.address;
		dec.size    = cmd.entry_size;
		dec.name    = cmd.entry_name_offset;
		// saturate line number, file index in upper half
		if (cmd.line_value > 32'(LINE_SAT)) begin
			dec.info = {cmd.entry_file_index, LINE_SAT};
		end else begin
			dec.info = {cmd.entry_file_index, cmd.line_value[15:0]};
		end
		unique case (cmd.mode)
			MODE_WSYM:  dec.op = OP_WSYM;
			MODE_WLINE: dec.op = OP_WLINE;
			MODE_LOOK:  dec.op = OP_LOOK;
			default:    dec.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

### hdl/asll_back.sv
// back end: table writes and the two binary searches, run side by side
// depends on asll_pkg and asll_ram
`default_nettype none
module asll_back import asll_pkg::*; #(
	parameter int SYMBOL_DEPTH = SYMBOL_DEPTH_DEF,
	parameter int LINE_DEPTH   = LINE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire entry_t             q_entry,
	output logic                    q_pop,
	input  wire logic [COUNT_W-1:0] symbol_count,
	input  wire logic [COUNT_W-1:0] line_count,
	output logic                    done,
	output result_t                 result
);
	localparam int SAW = $clog2(SYMBOL_DEPTH);
	localparam int SCW = $clog2(SYMBOL_DEPTH + 1);
	localparam int LAW = $clog2(LINE_DEPTH);
	localparam int LCW = $clog2(LINE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_CHECK = 3'b100
	} state_t;

	state_t state_q;

	logic [31:0]  addr_q;
	logic [SCW-1:0] s_lo_q, s_hi_q, s_n;
	logic [LCW-1:0] l_lo_q, l_hi_q, l_n, l_n_q;
	logic [SAW-1:0] s_mid, s_mid_q;
	logic [LAW-1:0] l_mid, l_mid_q;
	logic [SCW:0]   s_sum;
	logic [LCW:0]   l_sum;
	logic s_act_q, l_act_q;
	logic fs_q, fl_q;
	logic [31:0] name_q, info_q;
	result_t res_q;
	result_t ack_res;
	logic    done_q;

	logic sym_we, line_we;
	logic [31:0] st_rd, sz_rd, nm_rd, lsa_rd, lsb_rd, li_rd;

	logic [31:0] s1;
	logic s_match, l_match;
	logic [SCW-1:0] s_lo_n, s_hi_n;
	logic [LCW-1:0] l_lo_n, l_hi_n;
	logic s_act_n, l_act_n;
	logic fs_n, fl_n;
	logic [31:0] name_n, info_n;

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign done   = done_q;
	assign result = res_q;

	// counts beyond the table depth act as the depth
	always_comb begin
		s_n = (32'(symbol_count) > 32'(SYMBOL_DEPTH)) ? SCW'(SYMBOL_DEPTH)
			: SCW'(symbol_count);
		l_n = (32'(line_count) > 32'(LINE_DEPTH)) ? LCW'(LINE_DEPTH) : LCW'(line_count);
	end

	always_comb begin
		s_sum = {1'b0, s_lo_q} + {1'b0, s_hi_q} - (SCW+1)'(1);
		l_sum = {1'b0, l_lo_q} + {1'b0, l_hi_q} - (LCW+1)'(1);
		s_mid = SAW'(s_sum[SCW:1]);
		l_mid = LAW'(l_sum[LCW:1]);
	end

	// result loaded at pop: writes acknowledge, everything else starts cleared
	always_comb begin
		ack_res     = '0;
		ack_res.hit = (q_entry.op == OP_WSYM) || (q_entry.op == OP_WLINE);
	end

	assign sym_we  = q_pop && (q_entry.op == OP_WSYM) &&
		(32'(q_entry.slot) < 32'(SYMBOL_DEPTH));
	assign line_we = q_pop && (q_entry.op == OP_WLINE) &&
		(32'(q_entry.slot) < 32'(LINE_DEPTH));

	asll_ram #(.WIDTH(32), .DEPTH(SYMBOL_DEPTH)) u_sym_start (
		.clk(clk), .we(sym_we), .waddr(SAW'(q_entry.slot)), .wdata(q_entry.address),
		.raddr(s_mid), .rdata(st_rd));
	asll_ram #(.WIDTH(32), .DEPTH(SYMBOL_DEPTH)) u_sym_size (
		.clk(clk), .we(sym_we), .waddr(SAW'(q_entry.slot)), .wdata(q_entry.size),
		.raddr(s_mid), .rdata(sz_rd));
	asll_ram #(.WIDTH(32), .DEPTH(SYMBOL_DEPTH)) u_sym_name (
		.clk(clk), .we(sym_we), .waddr(SAW'(q_entry.slot)), .wdata(q_entry.name),
		.raddr(s_mid), .rdata(nm_rd));
	// two copies of the line starts so entry m and m+1 come back together
	asll_ram #(.WIDTH(32), .DEPTH(LINE_DEPTH)) u_line_start_a (
		.clk(clk), .we(line_we), .waddr(LAW'(q_entry.slot)), .wdata(q_entry.address),
		.raddr(l_mid), .rdata(lsa_rd));
	asll_ram #(.WIDTH(32), .DEPTH(LINE_DEPTH)) u_line_start_b (
		.clk(clk), .we(line_we), .waddr(LAW'(q_entry.slot)), .wdata(q_entry.address),
		.raddr(l_mid + LAW'(1)), .rdata(lsb_rd));
	asll_ram #(.WIDTH(32), .DEPTH(LINE_DEPTH)) u_line_info (
		.clk(clk), .we(line_we), .waddr(LAW'(q_entry.slot)), .wdata(q_entry.info),
		.raddr(l_mid), .rdata(li_rd));

	// probe evaluation
	always_comb begin
		if (sz_rd == 32'd0) begin
			s_match = (addr_q == st_rd);
		end else begin
			s_match = (addr_q >= st_rd) && (addr_q < (st_rd + sz_rd));
		end
		if ((LCW'(l_mid_q) + LCW'(1)) < l_n_q) begin
			s1 = lsb_rd;
		end else begin
			s1 = lsa_rd + LAST_SPAN;
		end
		l_match = (addr_q >= lsa_rd) && (addr_q < s1);

		s_lo_n = s_lo_q;
		s_hi_n = s_hi_q;
		if (addr_q < st_rd) begin
			s_hi_n = SCW'(s_mid_q);
		end else begin
			s_lo_n = SCW'(s_mid_q) + SCW'(1);
		end
		l_lo_n = l_lo_q;
		l_hi_n = l_hi_q;
		if (addr_q < lsa_rd) begin
			l_hi_n = LCW'(l_mid_q);
		end else begin
			l_lo_n = LCW'(l_mid_q) + LCW'(1);
		end

		fs_n    = fs_q || (s_act_q && s_match);
		fl_n    = fl_q || (l_act_q && l_match);
		name_n  = (s_act_q && s_match) ? nm_rd : name_q;
		info_n  = (l_act_q && l_match) ? li_rd : info_q;
		s_act_n = s_act_q && !s_match && (s_lo_n < s_hi_n);
		l_act_n = l_act_q && !l_match && (l_lo_n < l_hi_n);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_q <= q_entry.address;
			s_lo_q <= '0;
			s_hi_q <= s_n;
			l_lo_q <= '0;
			l_hi_q <= l_n;
			l_n_q  <= l_n;
			name_q <= '0;
			info_q <= '0;
		end else if (state_q == ST_PROBE) begin
			s_mid_q <= s_mid;
			l_mid_q <= l_mid;
		end else if (state_q == ST_CHECK) begin
			if (s_act_q) begin
				s_lo_q <= s_lo_n;
				s_hi_q <= s_hi_n;
			end
			if (l_act_q) begin
				l_lo_q <= l_lo_n;
				l_hi_q <= l_hi_n;
			end
			name_q <= name_n;
			info_q <= info_n;
		end
		if (q_pop) begin
			res_q <= ack_res;
		end else if (state_q == ST_CHECK) begin
			res_q.found_symbol    <= fs_n;
			res_q.symbol_name_ofs <= name_n;
			res_q.found_line      <= fl_n;
			res_q.hit_line_number <= info_n[15:0];
			res_q.hit_file_index  <= info_n[31:16];
			res_q.hit             <= fs_n || fl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			s_act_q <= 1'b0;
			l_act_q <= 1'b0;
			fs_q    <= 1'b0;
			fl_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						fs_q    <= 1'b0;
						fl_q    <= 1'b0;
						s_act_q <= (q_entry.op == OP_LOOK) && (s_n != '0);
						l_act_q <= (q_entry.op == OP_LOOK) && (l_n != '0);
						if (q_entry.op == OP_LOOK && (s_n != '0 || l_n != '0)) begin
							state_q <= ST_PROBE;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_PROBE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					fs_q    <= fs_n;
					fl_q    <= fl_n;
					s_act_q <= s_act_n;
					l_act_q <= l_act_n;
					if (s_act_n || l_act_n) begin
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
